// ===== rtl/pfq_pkg.sv =====
// shared constants and types for the process record queue
`timescale 1ns / 1ps

package pfq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [15:0] pid;
    logic [7:0]  prio;
    logic [31:0] address;
    logic [31:0] memory;
    logic [15:0] runtime;
    logic        suspended;
  } proc_rec_t;

  typedef struct packed {
    logic [1:0] status;
    proc_rec_t  rec;
  } pfq_res_t;

endpackage

// ===== rtl/pfq_if.sv =====
// valid/ready channel interfaces for operations and results
`timescale 1ns / 1ps

interface pfq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] process_pid;
  logic [7:0]  process_priority;
  logic [31:0] process_address;
  logic [31:0] process_memory;
  logic [15:0] process_runtime;
  logic        process_suspended;

  modport source (
    output valid, operation, process_pid, process_priority, process_address,
           process_memory, process_runtime, process_suspended,
    input  ready
  );
  modport sink (
    input  valid, operation, process_pid, process_priority, process_address,
           process_memory, process_runtime, process_suspended,
    output ready
  );
endinterface

interface pfq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] out_pid;
  logic [7:0]  out_priority;
  logic [31:0] out_address;
  logic [31:0] out_memory;
  logic [15:0] out_runtime;
  logic        out_suspended;

  modport source (
    output valid, status, out_pid, out_priority, out_address, out_memory,
           out_runtime, out_suspended,
    input  ready
  );
  modport sink (
    input  valid, status, out_pid, out_priority, out_address, out_memory,
           out_runtime, out_suspended,
    output ready
  );
endinterface

// ===== rtl/pfq_store.sv =====
// record store: one write port, one read port with registered read data
`timescale 1ns / 1ps

module pfq_store import pfq_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  proc_rec_t        wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output proc_rec_t        rdata_o
);

  proc_rec_t mem_q [QUEUE_DEPTH];
  proc_rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/process_fifo_with_pid_removal_top.sv =====
// process record queue with push, pop and delete by pid
`timescale 1ns / 1ps

// Ordered queue of process records held in a circular record store with a
// head pointer and an entry count. One operation is taken at a time; ready
// is high only while the sequencer is idle, and the result is held in an
// output register until it is transferred. A push, a refused push, an
// unused operation code and any operation on an empty queue go from idle
// straight to the response state. A pop first reads the head record (one
// store read). A delete walks the queue from the head, one record per
// cycle through the single read port and the pid comparator; after a match
// at position k the records behind it are moved up one place per cycle.
// The store needs no clearing after reset.
module process_fifo_with_pid_removal_top import pfq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  pfq_in_if.sink   in_i,
  pfq_out_if.source out_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_POP    = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  localparam logic [CNT_W+1:0] DEPTH_X  = (CNT_W + 2)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [15:0]      key_q, key_d;
  pfq_res_t         res_q, res_d;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  proc_rec_t        wdata, rdata, in_rec;
  logic [CNT_W:0]   cnt_ext, pos_ext, pos_p1, pos_p2;

  // logical position to store slot, wrapping past the end of the store
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [CNT_W:0] off);
    logic [CNT_W+1:0] sum;
    sum = (CNT_W + 2)'(head) + (CNT_W + 2)'(off);
    if (sum >= DEPTH_X) begin
      sum = sum - DEPTH_X;
    end
    return sum[IDX_W-1:0];
  endfunction

  assign cnt_ext = {1'b0, count_q};
  assign pos_ext = {1'b0, pos_q};
  assign pos_p1  = pos_ext + (CNT_W + 1)'(1);
  assign pos_p2  = pos_ext + (CNT_W + 1)'(2);

  assign in_rec.pid       = in_i.process_pid;
  assign in_rec.prio      = in_i.process_priority;
  assign in_rec.address   = in_i.process_address;
  assign in_rec.memory    = in_i.process_memory;
  assign in_rec.runtime   = in_i.process_runtime;
  assign in_rec.suspended = in_i.process_suspended;

  pfq_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    count_d = count_q;
    pos_d   = pos_q;
    key_d   = key_q;
    res_d   = res_q;
    we      = 1'b0;
    waddr   = phys(head_q, cnt_ext);
    wdata   = in_rec;
    raddr   = head_q;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          key_d        = in_i.process_pid;
          res_d        = '0;
          res_d.status = ST_MISS;
          pos_d        = '0;
          state_d      = S_RESP;
          case (in_i.operation)
            OP_PUSH: begin
              if (count_q == CNT_FULL) begin
                res_d.status = ST_FULL;
              end else begin
                we           = 1'b1;
                count_d      = count_q + CNT_W'(1);
                res_d.status = ST_OK;
              end
            end
            OP_POP: begin
              if (count_q != '0) begin
                state_d = S_POP;
              end
            end
            OP_DELETE: begin
              if (count_q != '0) begin
                state_d = S_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        res_d.status = ST_OK;
        res_d.rec    = rdata;
        head_d       = phys(head_q, (CNT_W + 1)'(1));
        count_d      = count_q - CNT_W'(1);
        state_d      = S_RESP;
      end
      S_SEARCH: begin
        // read data holds the record at pos_q; fetch the next one meanwhile
        raddr = phys(head_q, pos_p1);
        if (rdata.pid == key_q) begin
          res_d.status = ST_OK;
          res_d.rec    = rdata;
          if (pos_p1 == cnt_ext) begin
            count_d = count_q - CNT_W'(1);
            state_d = S_RESP;
          end else begin
            state_d = S_SHIFT;
          end
        end else if (pos_p1 == cnt_ext) begin
          state_d = S_RESP;
        end else begin
          pos_d = pos_p1[CNT_W-1:0];
        end
      end
      S_SHIFT: begin
        // read data holds the record at pos_q + 1, which moves up to pos_q
        raddr = phys(head_q, pos_p2);
        we    = 1'b1;
        waddr = phys(head_q, pos_ext);
        wdata = rdata;
        pos_d = pos_p1[CNT_W-1:0];
        if (pos_p2 == cnt_ext) begin
          count_d = count_q - CNT_W'(1);
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    res_q <= res_d;
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = (state_q == S_RESP);
  assign out_o.status        = res_q.status;
  assign out_o.out_pid       = res_q.rec.pid;
  assign out_o.out_priority  = res_q.rec.prio;
  assign out_o.out_address   = res_q.rec.address;
  assign out_o.out_memory    = res_q.rec.memory;
  assign out_o.out_runtime   = res_q.rec.runtime;
  assign out_o.out_suspended = res_q.rec.suspended;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("entry count beyond queue depth");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(head_q) < QUEUE_DEPTH)
    else $error("head pointer outside the store");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1)) ||
    (count_q + CNT_W'(1) == $past(count_q)))
    else $error("entry count moved by more than one");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (pos_p2 <= cnt_ext))
    else $error("record move beyond the tail");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status != ST_OK)) |->
      (out_o.out_pid == '0 && out_o.out_address == '0 && out_o.out_memory == '0))
    else $error("failed operation returned record data");
`endif

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for the process record queue
`timescale 1ns / 1ps

module tb;
  import pfq_pkg::*;

  // operation code that the block has no use for
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_OPS = 1270;
  localparam int unsigned DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;

  typedef struct {
    logic [1:0]  op;
    int unsigned count;
    proc_rec_t   rec;
    bit          fixed;
    pfq_res_t    want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  pfq_in_if  op_ch ();
  pfq_out_if res_ch ();

  process_fifo_with_pid_removal_top uut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (op_ch),
    .out_o  (res_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // typed-in expectation travels with the operation it belongs to
  logic     op_fixed;
  pfq_res_t op_fixed_res;

  proc_rec_t   record_queue[$];
  pfq_res_t    expected_results[$];
  stim_row_t   directed_rows[$];
  logic [15:0] pid_pool [0:7] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001,
                                  16'h1234, 16'hA5A5, 16'h5A5A, 16'h7FFF};

  int unsigned error_count = 0;
  int unsigned results_seen = 0;
  int unsigned push_count = 0, pop_count = 0, delete_hits = 0, delete_misses = 0;
  int unsigned full_refusals = 0, empty_misses = 0, unused_ops = 0, max_depth = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0, stall_left = 0, stall_phase = 0;

  pfq_res_t  predicted;
  pfq_res_t  oldest;
  proc_rec_t taken_rec;

  // predictor: applies one operation to the shadow queue and returns its result
  function automatic pfq_res_t apply_operation(logic [1:0] op, proc_rec_t rec);
    pfq_res_t res;
    int       hit;
    res = '0;
    res.status = ST_MISS;
    case (op)
      OP_PUSH: begin
        if (record_queue.size() >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
          full_refusals++;
        end else begin
          record_queue.push_back(rec);
          res.status = ST_OK;
          push_count++;
          if (record_queue.size() > max_depth) max_depth = record_queue.size();
        end
      end
      OP_POP: begin
        if (record_queue.size() != 0) begin
          res.rec = record_queue.pop_front();
          res.status = ST_OK;
          pop_count++;
        end else begin
          empty_misses++;
        end
      end
      OP_DELETE: begin
        hit = -1;
        foreach (record_queue[k]) begin
          if (hit < 0 && record_queue[k].pid == rec.pid) hit = k;
        end
        if (hit >= 0) begin
          res.rec = record_queue[hit];
          record_queue.delete(hit);
          res.status = ST_OK;
          delete_hits++;
        end else begin
          delete_misses++;
        end
      end
      default: unused_ops++;
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // result transfers are checked first, then the operation transfer of the
  // same edge is predicted
  always @(posedge clk) begin
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no operation outstanding");
          error_count++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("status", 32'(oldest.status), 32'(res_ch.status));
          check_field("out_pid", 32'(oldest.rec.pid), 32'(res_ch.out_pid));
          check_field("out_priority", 32'(oldest.rec.prio), 32'(res_ch.out_priority));
          check_field("out_address", oldest.rec.address, res_ch.out_address);
          check_field("out_memory", oldest.rec.memory, res_ch.out_memory);
          check_field("out_runtime", 32'(oldest.rec.runtime), 32'(res_ch.out_runtime));
          check_field("out_suspended", 32'(oldest.rec.suspended),
                      32'(res_ch.out_suspended));
          results_seen++;
        end
      end
      if (op_ch.valid && op_ch.ready) begin
        taken_rec.pid       = op_ch.process_pid;
        taken_rec.prio      = op_ch.process_priority;
        taken_rec.address   = op_ch.process_address;
        taken_rec.memory    = op_ch.process_memory;
        taken_rec.runtime   = op_ch.process_runtime;
        taken_rec.suspended = op_ch.process_suspended;
        predicted = apply_operation(op_ch.operation, taken_rec);
        expected_results.push_back(op_fixed ? op_fixed_res : predicted);
      end
    end
  end

  // receiver stalls: always ready, random, or a fixed two-in-five pattern
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(50, 300);
    end
    stall_left--;
    stall_phase = (stall_phase + 1) % 5;
    case (stall_mode)
      0:       res_ch.ready <= 1'b1;
      1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
      default: res_ch.ready <= (stall_phase >= 2);
    endcase
  end

  function automatic proc_rec_t random_record(logic [15:0] pid);
    proc_rec_t rec;
    rec.pid       = pid;
    rec.prio      = 8'($urandom);
    rec.address   = $urandom;
    rec.memory    = $urandom;
    rec.runtime   = 16'($urandom);
    rec.suspended = 1'($urandom_range(0, 1));
    return rec;
  endfunction

  function automatic logic [15:0] pick_pid();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return pid_pool[$urandom_range(0, 7)];
  endfunction

  function automatic stim_row_t make_row(logic [1:0] op, int unsigned count,
                                         proc_rec_t rec, bit fixed,
                                         logic [1:0] status, proc_rec_t out_rec);
    stim_row_t row;
    row.op = op;
    row.count = count;
    row.rec = rec;
    row.fixed = fixed;
    row.want.status = status;
    row.want.rec = out_rec;
    return row;
  endfunction

  // holds valid until the transfer, then either goes on with the burst or idles
  task automatic send_op(input logic [1:0] op, input proc_rec_t rec,
                         input bit fixed, input pfq_res_t want);
    op_ch.valid             <= 1'b1;
    op_ch.operation         <= op;
    op_ch.process_pid       <= rec.pid;
    op_ch.process_priority  <= rec.prio;
    op_ch.process_address   <= rec.address;
    op_ch.process_memory    <= rec.memory;
    op_ch.process_runtime   <= rec.runtime;
    op_ch.process_suspended <= rec.suspended;
    op_fixed                <= fixed;
    op_fixed_res            <= want;
    @(posedge clk);
    while (!op_ch.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      op_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(0, 12);
    end
  endtask

  initial begin
    proc_rec_t   ones_rec, zero_rec, rec;
    stim_row_t   row;
    logic [1:0]  op;
    int unsigned counted, phase, phase_left, push_pct, pick;

    op_ch.valid = 1'b0;
    op_ch.operation = OP_PUSH;
    op_ch.process_pid = '0;
    op_ch.process_priority = '0;
    op_ch.process_address = '0;
    op_ch.process_memory = '0;
    op_ch.process_runtime = '0;
    op_ch.process_suspended = 1'b0;
    res_ch.ready = 1'b0;
    op_fixed = 1'b0;
    op_fixed_res = '0;
    ones_rec = '1;
    zero_rec = '0;

    // empty queue, extremes, fill to full, deletes at head/middle/tail, drain
    directed_rows.push_back(make_row(OP_POP, 1, zero_rec, 1, ST_MISS, zero_rec));
    directed_rows.push_back(make_row(OP_DELETE, 1, zero_rec, 1, ST_MISS, zero_rec));
    directed_rows.push_back(make_row(OP_UNUSED, 1, ones_rec, 1, ST_MISS, zero_rec));
    directed_rows.push_back(make_row(OP_PUSH, 1, ones_rec, 1, ST_OK, zero_rec));
    directed_rows.push_back(make_row(OP_PUSH, 1, zero_rec, 1, ST_OK, zero_rec));
    directed_rows.push_back(make_row(OP_DELETE, 1, ones_rec, 1, ST_OK, ones_rec));
    directed_rows.push_back(make_row(OP_POP, 1, zero_rec, 1, ST_OK, zero_rec));
    rec = '{pid: 16'h0100, prio: 8'h00, address: '0, memory: '0, runtime: '0,
            suspended: 1'b0};
    directed_rows.push_back(make_row(OP_PUSH, 14, rec, 0, ST_OK, zero_rec));
    rec = '{pid: 16'h0100, prio: 8'h33, address: 32'h8000_0001,
            memory: 32'h7FFF_FFFE, runtime: 16'h00FF, suspended: 1'b1};
    directed_rows.push_back(make_row(OP_PUSH, 1, rec, 0, ST_OK, zero_rec));
    rec.pid = 16'hBEEF;
    directed_rows.push_back(make_row(OP_PUSH, 1, rec, 1, ST_OK, zero_rec));
    directed_rows.push_back(make_row(OP_PUSH, 1, ones_rec, 1, ST_FULL, zero_rec));
    directed_rows.push_back(make_row(OP_UNUSED, 1, zero_rec, 1, ST_MISS, zero_rec));
    rec.pid = 16'h0100;
    directed_rows.push_back(make_row(OP_DELETE, 1, rec, 0, ST_OK, zero_rec));
    directed_rows.push_back(make_row(OP_DELETE, 1, rec, 0, ST_OK, zero_rec));
    rec.pid = 16'h0107;
    directed_rows.push_back(make_row(OP_DELETE, 1, rec, 0, ST_OK, zero_rec));
    rec.pid = 16'hBEEF;
    directed_rows.push_back(make_row(OP_DELETE, 1, rec, 0, ST_OK, zero_rec));
    rec.pid = 16'h4242;
    directed_rows.push_back(make_row(OP_DELETE, 1, rec, 1, ST_MISS, zero_rec));
    directed_rows.push_back(make_row(OP_POP, 1, zero_rec, 0, ST_OK, zero_rec));
    directed_rows.push_back(make_row(OP_POP, 11, zero_rec, 0, ST_OK, zero_rec));
    directed_rows.push_back(make_row(OP_POP, 1, zero_rec, 1, ST_MISS, zero_rec));

    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      for (int unsigned i = 0; i < row.count; i++) begin
        rec = (row.count > 1) ? random_record(16'(row.rec.pid + i)) : row.rec;
        send_op(row.op, rec, row.fixed, row.want);
      end
    end

    // random part: phases that favour growth, shrinkage or balance
    counted = 0;
    phase = 0;
    phase_left = 0;
    while (counted < RANDOM_OPS) begin
      if (phase_left == 0) begin
        phase = $urandom_range(0, 2);
        phase_left = $urandom_range(30, 90);
      end
      phase_left--;
      push_pct = (phase == 0) ? 70 : (phase == 1) ? 25 : 45;
      pick = $urandom_range(0, 99);
      if (pick < 3) op = OP_UNUSED;
      else if (pick < push_pct) op = OP_PUSH;
      else if (pick < push_pct + (100 - push_pct) / 2) op = OP_POP;
      else op = OP_DELETE;
      send_op(op, random_record(pick_pid()), 1'b0, '0);
      if (op != OP_UNUSED) counted++;
    end
    op_ch.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d pushes, %0d pops, %0d deletes found, %0d deletes missed",
             push_count, pop_count, delete_hits, delete_misses);
    $display("%0d pushes refused when full, %0d empty pops, %0d unused codes, depth %0d",
             full_refusals, empty_misses, unused_ops, max_depth);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
